// File: hdl/bitmap_block_allocator_assert.svh
// Assertion macros for the bitmap block allocator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bitmap block allocator check failed");
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap block allocator check failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: hdl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// No dependencies.
package bba_pkg;
  localparam int unsigned MaxBlocks = 4096;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned NumWords  = MaxBlocks / WordBits;
  localparam int unsigned WaW       = $clog2(NumWords);
  localparam int unsigned BlkW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = BlkW + 1;
  localparam int unsigned BitW      = $clog2(WordBits);

  typedef logic [WordBits-1:0] word_t;
  typedef logic [WaW-1:0]      waddr_t;
  typedef logic [BlkW-1:0]     blk_t;
  typedef logic [CntW-1:0]     cnt_t;

  localparam word_t FullWord = '1;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_TEST    = 2'd2,
    KIND_RESERVE = 2'd3
  } kind_e;
endpackage

// File: hdl/bba_map.sv
// Usage bitmap memory: 128 x 32, registered read.
// Per-word valid flags make unwritten words read as all used. Uses bba_pkg.
module bba_map (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  bba_pkg::waddr_t rd_addr_i,
  output bba_pkg::word_t  rd_data_o,
  input  logic            wr_en_i,
  input  bba_pkg::waddr_t wr_addr_i,
  input  bba_pkg::word_t  wr_data_i
);
  import bba_pkg::*;

  word_t                mem [NumWords];
  logic [NumWords-1:0]  vld_q;
  word_t                rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : FullWord;
endmodule

// File: hdl/bitmap_block_allocator.sv
// Bitmap block allocator, first fit, one bit per block (1 = used).
// Uses bba_pkg, bba_map and bitmap_block_allocator_assert.svh.
//
// Usage:
//   Input beats on s_axis: tuser = kind (allocate, free, test, reserve),
//   tdata = {count, block}. One result beat per input beat on m_axis.
//   cfg_we_i/cfg_wdata_i write total_blocks and re-initialize the map:
//   every block used, used count equal to the clamped total. Write only
//   while the block is idle.
// Sequencing, one item at a time:
//   test reads the word of its block, then finishes; free/reserve read and
//   rewrite each bitmap word touched, or go straight to done if none.
//   allocate: one word read per cycle; on a hit the scan stops and the
//   run is marked word by word; a miss scans every word; count 0 or a full
//   map goes straight to done. Each word is updated by read-modify-write.
// Reset: whole map reads as used (per-word valid flags cleared at once, no
//   clearing pass), total = 4096, used count = 4096.
// Stall: the result sits in an output register; the next item is accepted
//   meanwhile, and a finished item waits in the done state until the
//   output register frees up.
module bitmap_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,      // total_blocks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // [11:0] block, [24:12] count, rest 0
  input  logic [1:0]  s_axis_tuser,     // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata      // [0] ok, [12:1] result_block,
                                        // [13] is_used, [26:14] used_count
);
  import bba_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MRD  = 3'd2;
  localparam logic [2:0] ST_MWR  = 3'd3;
  localparam logic [2:0] ST_TST  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]   state_q, state_d;
  cnt_t         tot_q, used_q, used_d;
  logic [WaW:0] words_q;               // scan length in words, up to NumWords
  kind_e        kind_q, kind_d;
  blk_t         blk_q, blk_d;
  cnt_t         cnt_q, cnt_d;
  logic         ok_q, ok_d, isu_q, isu_d;
  blk_t         res_q, res_d;
  // scan state
  logic [WaW:0] wi_q, wi_d;            // next word to read
  logic         ev_q, ev_d;            // a word is back from memory
  waddr_t       ew_q, ew_d;            // its index
  cnt_t         run_q, run_d;          // free run ending at previous word
  blk_t         first_q, first_d;
  // range walk
  blk_t         lo_q, lo_d;
  logic [CntW:0] hi_q, hi_d;           // exclusive end, clipped to total
  waddr_t       mw_q, mw_d, mlast_q, mlast_d;
  logic         set_q, set_d;
  // output register
  logic         mv_q, mv_d;
  logic [31:0]  mdata_q, mdata_d;

  waddr_t rd_addr, wr_addr;
  word_t  rd_data, wr_data;
  logic   wr_en;

  bba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  logic  in_acc;
  blk_t  in_blk;
  cnt_t  in_cnt;
  kind_e in_kind;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_blk  = s_axis_tdata[BlkW-1:0];
  assign in_cnt  = s_axis_tdata[BlkW+CntW-1:BlkW];
  assign in_kind = kind_e'(s_axis_tuser);

  // ---- scan word evaluation ----
  logic [BlkW+1:0] base;               // word base; base plus a word may reach past total
  word_t           v, fr, lm;
  logic [WordBits-1:0] hit;
  logic [BitW:0]   lz, hz;
  logic            any_hit, carry_hit;
  logic [BitW-1:0] hit_pos;
  logic [BitW:0]   tot_off;

  always_comb begin
    base    = {2'b00, ew_q, {BitW{1'b0}}};
    tot_off = '0;
    v       = rd_data;
    // blocks at or past the total count as used
    if (base + (BlkW+2)'(WordBits) > (BlkW+2)'(tot_q)) begin
      tot_off = (BitW+1)'((BlkW+2)'(tot_q) - base);
      v       = v | (FullWord << tot_off[BitW-1:0]);
    end
    fr = ~v;
    for (int k = 0; k < WordBits; k++) begin
      lm[k] = (cnt_t'(k) < cnt_q);
    end
    for (int s = 0; s < WordBits; s++) begin
      hit[s] = (cnt_q <= cnt_t'(WordBits)) && (((~(fr >> s)) & lm) == '0);
    end
    any_hit = |hit;
    hit_pos = '0;
    for (int s = WordBits-1; s >= 0; s--) begin
      if (hit[s]) hit_pos = BitW'(s);
    end
    lz = (BitW+1)'(WordBits);
    for (int s = WordBits-1; s >= 0; s--) begin
      if (v[s]) lz = (BitW+1)'(s);
    end
    hz = (BitW+1)'(WordBits);
    for (int s = 0; s < WordBits; s++) begin
      if (v[s]) hz = (BitW+1)'(WordBits-1-s);
    end
    carry_hit = (run_q != '0) &&
                ((CntW+1)'(run_q) + (CntW+1)'(lz) >= (CntW+1)'(cnt_q));
  end

  // ---- range walk mask ----
  logic [BitW-1:0] lob, hib;
  logic [CntW:0]   hm1;
  word_t           mask, wdat;
  always_comb begin
    hm1  = hi_q - 1'b1;
    lob  = (mw_q == lo_q[BlkW-1:BitW]) ? lo_q[BitW-1:0] : '0;
    hib  = (mw_q == mlast_q) ? hm1[BitW-1:0] : BitW'(WordBits-1);
    mask = (FullWord << lob) & (FullWord >> (BitW'(WordBits-1) - hib));
    wdat = set_q ? (rd_data | mask) : (rd_data & ~mask);
  end

  // range setup helper, shared by free/reserve accept and allocate hit
  blk_t          rs_lo;
  cnt_t          rs_cnt;
  logic [CntW:0] rs_hi_raw, rs_hi, rs_hm1;
  always_comb begin
    rs_lo     = (state_q == ST_IDLE) ? in_blk : res_d;
    rs_cnt    = (state_q == ST_IDLE) ? in_cnt : cnt_q;
    rs_hi_raw = (CntW+1)'(rs_lo) + (CntW+1)'(rs_cnt);
    rs_hi     = (rs_hi_raw > (CntW+1)'(tot_q)) ? (CntW+1)'(tot_q) : rs_hi_raw;
    rs_hm1    = rs_hi - 1'b1;
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;  blk_d = blk_q;   cnt_d = cnt_q;
    ok_d    = ok_q;    isu_d = isu_q;   res_d = res_q;
    wi_d    = wi_q;    ev_d  = 1'b0;    ew_d  = ew_q;
    run_d   = run_q;   first_d = first_q;
    lo_d    = lo_q;    hi_d  = hi_q;    mw_d  = mw_q;  mlast_d = mlast_q;
    set_d   = set_q;   used_d = used_q;
    mv_d    = mv_q && !m_axis_tready;
    mdata_d = mdata_q;
    rd_addr = mw_q;
    wr_en   = 1'b0;
    wr_addr = mw_q;
    wr_data = wdat;

    case (state_q)
      ST_IDLE: begin
        rd_addr = in_blk[BlkW-1:BitW];
        if (in_acc) begin
          kind_d = in_kind;
          blk_d  = in_blk;
          cnt_d  = in_cnt;
          ok_d   = 1'b0;
          isu_d  = 1'b0;
          res_d  = '0;
          set_d  = (in_kind != KIND_FREE);
          lo_d   = rs_lo;
          hi_d   = rs_hi;
          mw_d   = rs_lo[BlkW-1:BitW];
          mlast_d = rs_hm1[BlkW-1:BitW];
          case (in_kind)
            KIND_ALLOC: begin
              wi_d  = '0;
              run_d = '0;
              state_d = (in_cnt != '0 && used_q < tot_q) ? ST_SCAN : ST_DONE;
            end
            KIND_TEST: state_d = ST_TST;
            default: begin
              ok_d = 1'b1;
              state_d = ((CntW+1)'(in_blk) < rs_hi) ? ST_MRD : ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_addr = wi_q[WaW-1:0];
        if (ev_q && (carry_hit || any_hit)) begin
          res_d   = carry_hit ? first_q : blk_t'(base) + blk_t'(hit_pos);
          ok_d    = 1'b1;
          lo_d    = rs_lo;
          hi_d    = rs_hi;
          mw_d    = rs_lo[BlkW-1:BitW];
          mlast_d = rs_hm1[BlkW-1:BitW];
          state_d = ST_MRD;
        end else begin
          if (ev_q) begin
            if (v == '0) begin
              run_d   = run_q + cnt_t'(WordBits);
              first_d = (run_q == '0) ? blk_t'(base) : first_q;
            end else begin
              run_d   = cnt_t'(hz);
              first_d = blk_t'(base + (BlkW+2)'(WordBits) - (BlkW+2)'(hz));
            end
          end
          if (wi_q < words_q) begin
            ev_d = 1'b1;
            ew_d = wi_q[WaW-1:0];
            wi_d = wi_q + 1'b1;
          end else if (!ev_q) begin
            state_d = ST_DONE;       // no fitting run
          end
        end
      end
      ST_MRD: begin
        rd_addr = mw_q;
        state_d = ST_MWR;
      end
      ST_MWR: begin
        wr_en = 1'b1;
        if (mw_q == mlast_q) begin
          state_d = ST_DONE;
        end else begin
          mw_d    = mw_q + 1'b1;
          state_d = ST_MRD;
        end
      end
      ST_TST: begin
        if ((CntW)'(blk_q) < tot_q) begin
          ok_d  = 1'b1;
          isu_d = rd_data[blk_q[BitW-1:0]];
        end else begin
          isu_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!mv_q || m_axis_tready) begin
          used_d = used_q;
          if (kind_q == KIND_FREE) begin
            used_d = (cnt_q >= used_q) ? '0 : used_q - cnt_q;
          end else if (kind_q == KIND_RESERVE || (kind_q == KIND_ALLOC && ok_q)) begin
            used_d = (cnt_q >= tot_q - used_q) ? tot_q : used_q + cnt_q;
          end
          mv_d    = 1'b1;
          mdata_d = {5'd0, used_d, isu_q, res_q, ok_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tot_q   <= cnt_t'(MaxBlocks);
      used_q  <= cnt_t'(MaxBlocks);
      words_q <= (WaW+1)'(NumWords);
      ev_q    <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
      mv_q    <= mv_d;
      if (cfg_we_i) begin
        // clamp to the map size and start over with every block used
        if (cfg_wdata_i > 13'(MaxBlocks)) begin
          tot_q   <= cnt_t'(MaxBlocks);
          used_q  <= cnt_t'(MaxBlocks);
          words_q <= (WaW+1)'(NumWords);
        end else begin
          tot_q   <= cfg_wdata_i;
          used_q  <= cfg_wdata_i;
          words_q <= (WaW+1)'((cfg_wdata_i + 13'(WordBits-1)) >> BitW);
        end
      end else begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;  blk_q <= blk_d;   cnt_q <= cnt_d;
    ok_q    <= ok_d;    isu_q <= isu_d;   res_q <= res_d;
    wi_q    <= wi_d;    ew_q  <= ew_d;
    run_q   <= run_d;   first_q <= first_d;
    lo_q    <= lo_d;    hi_q  <= hi_d;    mw_q  <= mw_d;  mlast_q <= mlast_d;
    set_q   <= set_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

`include "bitmap_block_allocator_assert.svh"
  `BBA_ASSERT(a_used_le_total, used_q <= tot_q)
  `BBA_ASSERT_IMPL(a_scan_in_range, (state_q == ST_SCAN) && ev_q, (WaW+1)'(ew_q) < words_q)
  `BBA_ASSERT_IMPL(a_walk_in_range, state_q == ST_MWR, mw_q <= mlast_q)
endmodule

// File: tb/bitmap_block_allocator_test.sv
// Self-checking testbench for bitmap_block_allocator: drives allocate, free,
// test and reserve beats, predicts each result beat with its own bitmap model.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module bitmap_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned StallLimit = 20000;

  // directed row: kind, block, count, expected fields when known
  typedef struct {
    kind_e       kind;
    logic [11:0] blk;
    logic [12:0] cnt;
    bit          known;
    logic        ok;
    logic [11:0] rblk;
    logic        used;
    logic [12:0] ucnt;
  } dir_row_t;

  typedef struct {
    logic        ok;
    logic [11:0] rblk;
    logic        used;
    logic [12:0] ucnt;
  } alloc_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  bitmap_block_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  bit          map_bits[MaxBlocks];
  int unsigned used_blocks;
  int unsigned total_cfg;

  alloc_res_t  pending_results[$];
  int          err_cnt = 0;
  int          ok_allocs = 0;
  int          beats_out = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned managed();
    return (total_cfg > MaxBlocks) ? MaxBlocks : total_cfg;
  endfunction

  function automatic void map_init(int unsigned tot);
    total_cfg = tot;
    foreach (map_bits[i]) map_bits[i] = 1'b1;
    used_blocks = managed();
  endfunction

  function automatic void mark_blocks(int unsigned b, int unsigned n, bit v);
    int unsigned tot;
    tot = managed();
    for (int unsigned i = 0; i < n; i++)
      if (b + i < tot) map_bits[b + i] = v;
  endfunction

  // first fit over the bitmap; blocks past the total read as used
  function automatic bit first_fit(int unsigned n, output int unsigned start);
    int unsigned tot, run;
    tot = managed();
    run = 0;
    start = 0;
    for (int unsigned b = 0; b < tot; b++) begin
      if (map_bits[b]) begin
        run = 0;
      end else begin
        if (run == 0) start = b;
        run++;
        if (run == n) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_res_t apply_op(kind_e kind, int unsigned b, int unsigned n);
    alloc_res_t  r;
    int unsigned tot, start;
    tot = managed();
    r = '{1'b0, '0, 1'b0, '0};
    if (used_blocks > tot) used_blocks = tot;
    case (kind)
      KIND_ALLOC: begin
        if (n != 0 && used_blocks < tot && first_fit(n, start)) begin
          mark_blocks(start, n, 1'b1);
          used_blocks = (n >= tot - used_blocks) ? tot : used_blocks + n;
          r.ok = 1'b1;
          r.rblk = start[11:0];
        end
      end
      KIND_FREE: begin
        mark_blocks(b, n, 1'b0);
        used_blocks = (n >= used_blocks) ? 0 : used_blocks - n;
        r.ok = 1'b1;
      end
      KIND_TEST: begin
        if (b < tot) begin
          r.ok = 1'b1;
          r.used = map_bits[b];
        end else begin
          r.used = 1'b1;
        end
      end
      default: begin
        mark_blocks(b, n, 1'b1);
        used_blocks = (n >= tot - used_blocks) ? tot : used_blocks + n;
        r.ok = 1'b1;
      end
    endcase
    r.ucnt = used_blocks[12:0];
    return r;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    alloc_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok = m_axis_tdata[0];
      got.rblk = m_axis_tdata[12:1];
      got.used = m_axis_tdata[13];
      got.ucnt = m_axis_tdata[26:14];
      beats_out++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.rblk !== want.rblk ||
            got.used !== want.used || got.ucnt !== want.ucnt) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp ok=%0d blk=%0d used=%0d cnt=%0d, got ok=%0d blk=%0d used=%0d cnt=%0d",
                     want.ok, want.rblk, want.used, want.ucnt,
                     got.ok, got.rblk, got.used, got.ucnt);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one input beat; expectation pushed when accepted
  task automatic send_op(kind_e kind, int unsigned b, int unsigned n,
                         output alloc_res_t predicted);
    do @(posedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, n[12:0], b[11:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_op(kind, b, n);
    pending_results.push_back(predicted);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_and_config(int unsigned tot);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tot[12:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    map_init(tot);
  endtask

  // random phase: mostly allocations and frees, with tests and reserves
  task automatic random_ops(int unsigned items);
    alloc_res_t  r;
    int unsigned tot, sel, b, n;
    kind_e       k;
    for (int i = 0; i < items; i++) begin
      tot = managed();
      sel = $urandom_range(99);
      b = $urandom_range(4095);
      if (tot > 0 && $urandom_range(3) != 0) b = $urandom_range(tot - 1);
      n = ($urandom_range(15) == 0) ? $urandom_range(8191) : $urandom_range(80);
      if (sel < 40) k = KIND_ALLOC;
      else if (sel < 70) k = KIND_FREE;
      else if (sel < 88) k = KIND_TEST;
      else k = KIND_RESERVE;
      send_op(k, b, n, r);
      if (k == KIND_ALLOC && r.ok) ok_allocs++;
    end
  endtask

  dir_row_t dir_rows[$];
  alloc_res_t dr;

  initial begin
    map_init(4096);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: all used, count at total
    dir_rows = '{
      '{KIND_TEST,    12'd0,    13'd0,    1, 1'b1, 12'd0, 1'b1, 13'd4096},
      '{KIND_TEST,    12'd4095, 13'd0,    1, 1'b1, 12'd0, 1'b1, 13'd4096},
      '{KIND_ALLOC,   12'd0,    13'd1,    1, 1'b0, 12'd0, 1'b0, 13'd4096},
      '{KIND_FREE,    12'd0,    13'd4096, 1, 1'b1, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd0,    1, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd4096, 1, 1'b1, 12'd0, 1'b0, 13'd4096},
      '{KIND_FREE,    12'd4095, 13'd8191, 1, 1'b1, 12'd0, 1'b0, 13'd0},
      '{KIND_FREE,    12'd0,    13'd100,  1, 1'b1, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd31,   0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd40,   0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_TEST,    12'd31,   13'd0,    0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_RESERVE, 12'd50,   13'd5,    0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_RESERVE, 12'd50,   13'd5,    0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd200,  0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_FREE,    12'd2000, 13'd4095, 0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_ALLOC,   12'd0,    13'd2000, 0, 1'b0, 12'd0, 1'b0, 13'd0},
      '{KIND_RESERVE, 12'd0,    13'd8191, 1, 1'b1, 12'd0, 1'b0, 13'd4096},
      '{KIND_TEST,    12'd2047, 13'd0,    1, 1'b1, 12'd0, 1'b1, 13'd4096}
    };
    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].kind, dir_rows[i].blk, dir_rows[i].cnt, dr);
      if (dir_rows[i].known && (dr.ok !== dir_rows[i].ok || dr.rblk !== dir_rows[i].rblk ||
          dr.used !== dir_rows[i].used || dr.ucnt !== dir_rows[i].ucnt)) begin
        err_cnt++;
        if (err_cnt <= 10) $display("directed row %0d disagrees with predictor", i);
      end
    end

    // total 0: test out of range, reserve saturates at zero, allocate fails
    drain_and_config(0);
    send_op(KIND_TEST, 0, 0, dr);
    send_op(KIND_RESERVE, 5, 10, dr);
    send_op(KIND_ALLOC, 0, 1, dr);
    // oversize total clamps to the maximum
    drain_and_config(8191);
    send_op(KIND_FREE, 4090, 6, dr);
    send_op(KIND_ALLOC, 0, 6, dr);
    // odd total: word scan ends in a partial word
    drain_and_config(77);
    send_op(KIND_FREE, 0, 4095, dr);
    send_op(KIND_TEST, 77, 0, dr);
    send_op(KIND_ALLOC, 0, 77, dr);

    // random phases across idle mixes and totals
    drain_and_config(4096);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_ops(400);
    drain_and_config(1000);
    send_idle_pct = 77; recv_stall_pct = 0;
    random_ops(350);
    drain_and_config(33);
    send_idle_pct = 0; recv_stall_pct = 77;
    random_ops(350);
    drain_and_config(4096);
    send_idle_pct = 11; recv_stall_pct = 11;
    random_ops(350);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d result beats, %0d successful allocations, totals 0..8191",
             beats_out, ok_allocs);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
